>>> hdl/b32h_pkg.sv
// Shared types and constants for the base32hex stream decoder.
package b32h_pkg;

  // Character classes found by the front end
  localparam logic [1:0] KIND_SYM = 2'd0;
  localparam logic [1:0] KIND_PAD = 2'd1;
  localparam logic [1:0] KIND_BAD = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_DATA    = 2'd0;
  localparam logic [1:0] STATUS_END_OK  = 2'd1;
  localparam logic [1:0] STATUS_END_ERR = 2'd2;

  // Character codes
  localparam logic [7:0] CHAR_PAD    = 8'h3D;  // '='
  localparam logic [7:0] CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE   = 8'h39;  // '9'
  localparam logic [7:0] CHAR_UP_A   = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UP_V   = 8'h56;  // 'V'
  localparam logic [7:0] CHAR_LO_A   = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LO_V   = 8'h76;  // 'v'
  localparam logic [4:0] LETTER_BASE = 5'd10;

  // Queue between front and back end
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // One classified character
  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] sym;
    logic       last;
  } item_t;

  // Queue status as seen by the back end
  typedef struct packed {
    logic  head_valid;
    item_t head;
  } q_head_t;

endpackage

>>> hdl/b32h_front.sv
// Front end: classify one character into symbol, pad or invalid.
module b32h_front (
  input  logic [7:0]    char_code,
  input  logic          final_char,
  output b32h_pkg::item_t item
);

  logic [7:0] diff;

  always_comb begin
    diff      = 8'd0;
    item.kind = b32h_pkg::KIND_BAD;
    item.sym  = 5'd0;
    item.last = final_char;
    if (char_code >= b32h_pkg::CHAR_ZERO && char_code <= b32h_pkg::CHAR_NINE) begin
      diff      = char_code - b32h_pkg::CHAR_ZERO;
      item.kind = b32h_pkg::KIND_SYM;
      item.sym  = diff[4:0];
    end else if (char_code >= b32h_pkg::CHAR_UP_A && char_code <= b32h_pkg::CHAR_UP_V) begin
      diff      = char_code - b32h_pkg::CHAR_UP_A;
      item.kind = b32h_pkg::KIND_SYM;
      item.sym  = diff[4:0] + b32h_pkg::LETTER_BASE;
    end else if (char_code >= b32h_pkg::CHAR_LO_A && char_code <= b32h_pkg::CHAR_LO_V) begin
      diff      = char_code - b32h_pkg::CHAR_LO_A;
      item.kind = b32h_pkg::KIND_SYM;
      item.sym  = diff[4:0] + b32h_pkg::LETTER_BASE;
    end else if (char_code == b32h_pkg::CHAR_PAD) begin
      item.kind = b32h_pkg::KIND_PAD;
    end
  end

endmodule

>>> hdl/b32h_queue.sv
// Short FIFO of classified characters between front and back end.
module b32h_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b32h_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output b32h_pkg::q_head_t q_head
);

  b32h_pkg::item_t entries [b32h_pkg::QUEUE_DEPTH];
  logic [b32h_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [b32h_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [b32h_pkg::QPTR_BITS:0]   count;

  assign full              = (count == (b32h_pkg::QPTR_BITS+1)'(b32h_pkg::QUEUE_DEPTH));
  assign q_head.head_valid = (count != '0);
  assign q_head.head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/b32h_back.sv
// Back end: bit accumulator, message mode, byte count and output register.
module b32h_back #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  b32h_pkg::q_head_t q_head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic [1:0]        status,
  output logic [15:0]       decoded_count
);

  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_STOPPED = 2'd1;
  localparam logic [1:0] MODE_ERROR   = 2'd2;

  logic [6:0]            leftover_bits, leftover_bits_next;
  logic [2:0]            bit_count, bit_count_next;
  logic [1:0]            mode, mode_next;
  logic [COUNT_BITS-1:0] byte_total, byte_total_next;
  logic                  pending_end, pending_end_next;

  logic [11:0]           acc;
  logic [3:0]            bits;
  logic [2:0]            nb;
  logic [6:0]            mask;
  logic [7:0]            byte_val;
  logic [COUNT_BITS-1:0] total_inc;
  logic [31:0]           total_wide;
  logic [15:0]           total_report;
  logic                  need_out, out_free, go;
  logic [7:0]            res_byte;
  logic [1:0]            res_status;
  logic [15:0]           res_count;
  logic                  state_clear;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    acc       = {leftover_bits, q_head.head.sym};
    bits      = {1'b0, bit_count} + 4'd5;
    nb        = bits[2:0];
    mask      = 7'((8'd1 << nb) - 8'd1);
    byte_val  = 8'(acc >> nb);
    total_inc = (byte_total != '1) ? byte_total + 1'b1 : byte_total;

    leftover_bits_next = leftover_bits;
    bit_count_next     = bit_count;
    mode_next          = mode;
    byte_total_next    = byte_total;
    pending_end_next   = pending_end;
    need_out           = 1'b0;
    pop                = 1'b0;
    state_clear        = 1'b0;
    res_byte           = 8'd0;
    res_status         = b32h_pkg::STATUS_DATA;
    res_count          = 16'd0;

    if (pending_end) begin
      need_out = 1'b1;
      res_status = (mode == MODE_ERROR) ? b32h_pkg::STATUS_END_ERR : b32h_pkg::STATUS_END_OK;
      pending_end_next = 1'b0;
      state_clear = 1'b1;
      pop = 1'b1;
    end else begin
      unique case (mode)
        MODE_NORMAL: begin
          unique case (q_head.head.kind)
            b32h_pkg::KIND_PAD: mode_next = MODE_STOPPED;
            b32h_pkg::KIND_SYM: begin
              leftover_bits_next = acc[6:0] & mask;
              bit_count_next     = nb;
              if (bits[3]) begin
                byte_total_next = total_inc;
                need_out        = 1'b1;
                res_byte        = byte_val;
                res_status      = b32h_pkg::STATUS_DATA;
              end
            end
            default: mode_next = MODE_ERROR;
          endcase
        end
        default: ;
      endcase
      if (q_head.head.last && need_out) begin
        // byte goes first, end word follows on the next slot
        pending_end_next = 1'b1;
      end else if (q_head.head.last) begin
        need_out   = 1'b1;
        res_status = (mode_next == MODE_ERROR) ? b32h_pkg::STATUS_END_ERR
                                               : b32h_pkg::STATUS_END_OK;
        state_clear = 1'b1;
        pop = 1'b1;
      end else begin
        pop = 1'b1;
      end
    end

    total_wide   = 32'(byte_total_next);
    total_report = (total_wide > 32'h0000_FFFF) ? 16'hFFFF : total_wide[15:0];
    if (res_status != b32h_pkg::STATUS_END_ERR) begin
      res_count = total_report;
    end

    go = q_head.head_valid && (!need_out || out_free);
    if (!go) pop = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits <= '0;
      bit_count     <= '0;
      mode          <= MODE_NORMAL;
      byte_total    <= '0;
      pending_end   <= 1'b0;
    end else if (go) begin
      pending_end <= pending_end_next;
      if (state_clear) begin
        leftover_bits <= '0;
        bit_count     <= '0;
        mode          <= MODE_NORMAL;
        byte_total    <= '0;
      end else begin
        leftover_bits <= leftover_bits_next;
        bit_count     <= bit_count_next;
        mode          <= mode_next;
        byte_total    <= byte_total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= go && need_out;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && go && need_out) begin
      out_byte      <= res_byte;
      status        <= res_status;
      decoded_count <= res_count;
    end
  end

endmodule

>>> hdl/base32hex_stream_decoder_unit.sv
// Base32hex stream decoder: one character per input word, data bytes and an end word out.
//
// Each input word carries one raw character and a last-of-message flag. Characters
// 0-9, A-V and a-v give five bits each, which are packed MSB first into bytes; each
// completed byte leaves as a data word (status 0) with the running count of bytes in
// the message. An '=' stops decoding until the last word; before it, any other character
// puts the message in error. The last word of a message always adds an end word: status 1
// with the byte count (saturating at 2^COUNT_BITS-1, then at 65535), or status 2 with
// byte and count zero. Leftover bits are dropped and the next message starts clean.
// Rate: one character per cycle while the queue is not full. A character that both
// completes a byte and ends the message yields two output words and holds the back end
// until both are out; the four-entry queue between the classifier and the back end
// absorbs that and output stalls. Results pass the queue and then the output register.
module base32hex_stream_decoder_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        final_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  status,
  output logic [15:0] decoded_count
);

  b32h_pkg::item_t   front_item;
  b32h_pkg::q_head_t q_head;
  logic              q_full;
  logic              q_push;
  logic              q_pop;

  // Classify the incoming character
  b32h_front u_front (
    .char_code  (char_code),
    .final_char (final_char),
    .item       (front_item)
  );

  // Hold off the sender only when the queue is full
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  b32h_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (front_item),
    .pop       (q_pop),
    .full      (q_full),
    .q_head    (q_head)
  );

  // Decode, count and register the results
  b32h_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_head        (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .status        (status),
    .decoded_count (decoded_count)
  );

endmodule

>>> hdl/b32h_checker.sv
// Port-level checks for the base32hex stream decoder, bound to the top level.
module b32h_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic [1:0]  status,
  input logic [15:0] decoded_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(status)
                               && $stable(decoded_count))
    else $error("output word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == b32h_pkg::STATUS_DATA || status == b32h_pkg::STATUS_END_OK
                  || status == b32h_pkg::STATUS_END_ERR)
    else $error("unknown status code");

  a_err_end_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == b32h_pkg::STATUS_END_ERR |-> out_byte == 8'd0
                                                        && decoded_count == 16'd0)
    else $error("error end carries data");

  a_ok_end_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == b32h_pkg::STATUS_END_OK |-> out_byte == 8'd0)
    else $error("ok end carries a byte");

  a_data_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == b32h_pkg::STATUS_DATA |-> decoded_count != 16'd0)
    else $error("data word with zero count");

endmodule

bind base32hex_stream_decoder_unit b32h_checker u_b32h_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_byte      (out_byte),
  .status        (status),
  .decoded_count (decoded_count)
);
